// ----- rtl/calendar_date_stepper_defines.svh -----
// ----------------------------------------------------------------------------
// calendar date stepper assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_STEPPER_DEFINES_SVH
`define CALENDAR_DATE_STEPPER_DEFINES_SVH
`ifndef SYNTHESIS
`define CDS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define CDS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CDS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CDS_ASSERT(lbl, cond, msg)
`define CDS_ASSERT_IMP(lbl, ante, cons, msg)
`define CDS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/cds_pkg.sv -----
// ----------------------------------------------------------------------------
// cds_pkg
// shared widths, constants, control types and calendar helpers
// ----------------------------------------------------------------------------
package cds_pkg;

	localparam int YearW  = 14;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int DowW   = 3;
	localparam int DeltaW = 16;
	localparam int StepW  = DeltaW + 1;

	localparam logic [YearW-1:0]  MaxYear    = YearW'(9999);
	localparam logic [YearW-1:0]  YearOffset = YearW'(400);
	localparam logic [MonthW-1:0] MonthJan   = MonthW'(1);
	localparam logic [MonthW-1:0] MonthFeb   = MonthW'(2);
	localparam logic [MonthW-1:0] MonthDec   = MonthW'(12);
	localparam logic [DayW-1:0]   DayFirst   = DayW'(1);
	localparam logic [DayW-1:0]   DayLast    = DayW'(31);

	// floor(y / 100) = (y * Recip100) >> Recip100Sh for y below 16384
	localparam int Recip100   = 5243;
	localparam int Recip100Sh = 19;
	// floor(s / 7) = (s * Recip7) >> Recip7Sh for s below 16384
	localparam int Recip7     = 18725;
	localparam int Recip7Sh   = 17;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAP,
		ST_CLAMP,
		ST_WALK,
		ST_WD1,
		ST_WD2,
		ST_WD3,
		ST_WD4
	} cds_state_t;

	typedef struct packed {
		logic capture;
		logic clamp;
		logic walk;
		logic wd_prep;
		logic wd_mul;
		logic wd_sum;
		logic out_load;
	} cds_cmd_t;

	typedef struct packed {
		logic walk_done;
	} cds_sts_t;

	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
		logic [DayW-1:0] len;
		unique case (m)
			4'd2:                      len = leap ? DayW'(29) : DayW'(28);
			4'd4, 4'd6, 4'd9, 4'd11:   len = DayW'(30);
			default:                   len = DayW'(31);
		endcase
		return len;
	endfunction

	// floor(3 * (m + 1) / 5) for the shifted month 3..14
	function automatic logic [3:0] kl_month_term(input logic [MonthW-1:0] m);
		logic [3:0] t;
		unique case (m)
			4'd3:         t = 4'd2;
			4'd4, 4'd5:   t = 4'd3;
			4'd6, 4'd7:   t = 4'd4;
			4'd8:         t = 4'd5;
			4'd9, 4'd10:  t = 4'd6;
			4'd11, 4'd12: t = 4'd7;
			4'd13:        t = 4'd8;
			4'd14:        t = 4'd9;
			default:      t = 4'd0;
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/cds_cmd_if.sv -----
// ----------------------------------------------------------------------------
// cds_cmd_if
// request channel: load or step beat with valid/ready handshake
// ----------------------------------------------------------------------------
interface cds_cmd_if;
	logic                             valid;
	logic                             ready;
	logic                             op;
	logic        [cds_pkg::YearW-1:0]  load_year;
	logic        [cds_pkg::MonthW-1:0] load_month;
	logic        [cds_pkg::DayW-1:0]   load_day;
	logic signed [cds_pkg::DeltaW-1:0] day_delta;

	modport source (output valid, op, load_year, load_month, load_day, day_delta, input ready);
	modport sink (input valid, op, load_year, load_month, load_day, day_delta, output ready);
endinterface

// ----- rtl/cds_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cds_rsp_if
// result channel: date, weekday and range flag with valid/ready handshake
// ----------------------------------------------------------------------------
interface cds_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [cds_pkg::YearW-1:0]   year;
	logic [cds_pkg::MonthW-1:0]  month;
	logic [cds_pkg::DayW-1:0]    day;
	logic [cds_pkg::DowW-1:0]    weekday;
	logic                        range_error;

	modport source (output valid, year, month, day, weekday, range_error, input ready);
	modport sink (input valid, year, month, day, weekday, range_error, output ready);
endinterface

// ----- rtl/calendar_date_stepper.sv -----
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Gregorian date register with load and signed day stepping.
//
// cmd channel: op 0 loads year/month/day (clamped into range), op 1 moves
// the stored date by day_delta days. rsp channel: one beat per cmd beat with
// the date, weekday (0 Monday .. 6 Sunday) and a flag set when a step ran
// into 0000-01-01 or 9999-12-31 and stopped there.
// A load runs from accept through the leap and clamp stages into the weekday
// pipeline. A step first runs the walker, which moves one day per cycle, then
// a four-stage weekday pipeline runs; a step that stops at a bound ends its
// walk there. One cmd beat is in work at a time; the next can be taken as soon
// as rsp valid rises, when the sequencer is back in idle. cmd ready is high
// while the sequencer is idle, also while a finished rsp beat still waits.
// After reset the date is 0000-01-01 and no rsp beat is pending. A stalled
// rsp holds its beat; the sequencer waits in its last stage until the
// output register is free.
// ----------------------------------------------------------------------------
module calendar_date_stepper (
	input logic        clk,
	input logic        arst_n,
	cds_cmd_if.sink    cmd,
	cds_rsp_if.source  rsp
);

	cds_pkg::cds_cmd_t ctl;
	cds_pkg::cds_sts_t sts;

	cds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_op    (cmd.op),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	cds_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.op          (cmd.op),
		.load_year   (cmd.load_year),
		.load_month  (cmd.load_month),
		.load_day    (cmd.load_day),
		.day_delta   (cmd.day_delta),
		.year        (rsp.year),
		.month       (rsp.month),
		.day         (rsp.day),
		.weekday     (rsp.weekday),
		.range_error (rsp.range_error)
	);

endmodule

// ----- rtl/cds_ctrl.sv -----
// ----------------------------------------------------------------------------
// cds_ctrl
// sequencer: load and clamp, day walk, weekday pipeline, result handoff
// ----------------------------------------------------------------------------
`include "calendar_date_stepper_defines.svh"

module cds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_op,
	output logic              cmd_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cds_pkg::cds_cmd_t ctl,
	input  cds_pkg::cds_sts_t sts
);

	cds_pkg::cds_state_t state_q;
	cds_pkg::cds_state_t state_nxt;
	logic                rsp_valid_q;
	logic                out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cds_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_nxt = (cmd_op == cds_pkg::OP_STEP) ? cds_pkg::ST_WALK : cds_pkg::ST_LEAP;
				end
			end
			cds_pkg::ST_LEAP:  state_nxt = cds_pkg::ST_CLAMP;
			cds_pkg::ST_CLAMP: state_nxt = cds_pkg::ST_WD1;
			cds_pkg::ST_WALK: begin
				if (sts.walk_done) begin
					state_nxt = cds_pkg::ST_WD1;
				end
			end
			cds_pkg::ST_WD1: state_nxt = cds_pkg::ST_WD2;
			cds_pkg::ST_WD2: state_nxt = cds_pkg::ST_WD3;
			cds_pkg::ST_WD3: state_nxt = cds_pkg::ST_WD4;
			cds_pkg::ST_WD4: begin
				if (out_free) begin
					state_nxt = cds_pkg::ST_IDLE;
				end
			end
			default: state_nxt = cds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			cds_pkg::ST_IDLE: begin
				cmd_ready   = 1'b1;
				ctl.capture = cmd_valid;
			end
			cds_pkg::ST_CLAMP: ctl.clamp   = 1'b1;
			cds_pkg::ST_WALK:  ctl.walk    = 1'b1;
			cds_pkg::ST_WD1:   ctl.wd_prep = 1'b1;
			cds_pkg::ST_WD2:   ctl.wd_mul  = 1'b1;
			cds_pkg::ST_WD3:   ctl.wd_sum  = 1'b1;
			cds_pkg::ST_WD4:   ctl.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cds_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`CDS_ASSERT_IMP(a_rsp_from_wd4, $rose(rsp_valid_q), $past(state_q) == cds_pkg::ST_WD4, "result raised outside weekday stage")
	`CDS_ASSERT_NXT(a_walk_exit, state_q == cds_pkg::ST_WALK && sts.walk_done, state_q == cds_pkg::ST_WD1, "walk did not hand off to weekday pipeline")
	`CDS_ASSERT_NXT(a_load_path, cmd_valid && cmd_ready && cmd_op == cds_pkg::OP_LOAD, state_q == cds_pkg::ST_LEAP, "load beat did not enter leap stage")

endmodule

// ----- rtl/cds_datapath.sv -----
// ----------------------------------------------------------------------------
// cds_datapath
// date registers, day walker, leap flag and weekday arithmetic
// ----------------------------------------------------------------------------
`include "calendar_date_stepper_defines.svh"

module cds_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cds_pkg::cds_cmd_t                 ctl,
	output cds_pkg::cds_sts_t                 sts,
	input  logic                              op,
	input  logic        [cds_pkg::YearW-1:0]  load_year,
	input  logic        [cds_pkg::MonthW-1:0] load_month,
	input  logic        [cds_pkg::DayW-1:0]   load_day,
	input  logic signed [cds_pkg::DeltaW-1:0] day_delta,
	output logic        [cds_pkg::YearW-1:0]  year,
	output logic        [cds_pkg::MonthW-1:0] month,
	output logic        [cds_pkg::DayW-1:0]   day,
	output logic        [cds_pkg::DowW-1:0]   weekday,
	output logic                              range_error
);

	localparam int YW = cds_pkg::YearW;
	localparam int MW = cds_pkg::MonthW;
	localparam int DW = cds_pkg::DayW;
	localparam int SW = cds_pkg::StepW;
	localparam int P100W = YW + 13;
	localparam int P7W   = YW + 15;

	logic [YW-1:0] cur_year_q;
	logic [MW-1:0] cur_month_q;
	logic [DW-1:0] cur_day_q;
	logic [SW-1:0] steps_q;
	logic          back_q;
	logic          leap_q;
	logic          err_q;

	// leap flag of the stored year, registered so it follows the year in the next cycle
	logic [P100W-1:0] y_prod;
	logic [7:0]       y_q100;
	logic             y_div100;
	logic             leap_d;

	assign y_prod   = P100W'(cur_year_q) * P100W'(cds_pkg::Recip100);
	assign y_q100   = y_prod[cds_pkg::Recip100Sh +: 8];
	assign y_div100 = (cur_year_q == YW'({6'd0, y_q100} * YW'(100)));
	assign leap_d   = (cur_year_q[1:0] == 2'd0 && !y_div100) || (y_div100 && y_q100[1:0] == 2'd0);

	// load clamping
	logic [YW-1:0] ld_year;
	logic [MW-1:0] ld_month;
	logic [DW-1:0] ld_day;

	assign ld_year  = (load_year > cds_pkg::MaxYear) ? cds_pkg::MaxYear : load_year;
	assign ld_month = (load_month == '0) ? cds_pkg::MonthJan :
		(load_month > cds_pkg::MonthDec) ? cds_pkg::MonthDec : load_month;
	assign ld_day   = (load_day == '0) ? cds_pkg::DayFirst : load_day;

	// step magnitude
	logic          delta_neg;
	logic [SW-1:0] delta_mag;

	assign delta_neg = day_delta[cds_pkg::DeltaW-1];
	assign delta_mag = delta_neg ? (SW'(0) - SW'(day_delta)) : SW'(day_delta);

	// one-day walk
	logic [DW-1:0] len_cur;
	logic [MW-1:0] month_prev;
	logic [DW-1:0] len_prev;
	logic          at_max;
	logic          at_min;
	logic          clamp_len;

	assign len_cur    = cds_pkg::month_len(cur_month_q, leap_q);
	assign month_prev = cur_month_q - MW'(1);
	assign len_prev   = cds_pkg::month_len(month_prev, leap_q);
	assign at_max     = cur_year_q == cds_pkg::MaxYear && cur_month_q == cds_pkg::MonthDec &&
		cur_day_q == cds_pkg::DayLast;
	assign at_min     = cur_year_q == '0 && cur_month_q == cds_pkg::MonthJan &&
		cur_day_q == cds_pkg::DayFirst;
	assign clamp_len  = cur_day_q > len_cur;

	assign sts.walk_done = (steps_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q  <= '0;
			cur_month_q <= cds_pkg::MonthJan;
			cur_day_q   <= cds_pkg::DayFirst;
			steps_q     <= '0;
			back_q      <= 1'b0;
			leap_q      <= 1'b1;
			err_q       <= 1'b0;
		end else begin
			leap_q <= leap_d;
			if (ctl.capture) begin
				err_q <= 1'b0;
				if (op == cds_pkg::OP_LOAD) begin
					cur_year_q  <= ld_year;
					cur_month_q <= ld_month;
					cur_day_q   <= ld_day;
				end else begin
					steps_q <= delta_mag;
					if (delta_mag != '0) begin
						back_q <= delta_neg;
					end
				end
			end else if (ctl.clamp) begin
				if (clamp_len) begin
					cur_day_q <= len_cur;
				end
			end else if (ctl.walk && steps_q != '0) begin
				if (!back_q) begin
					if (at_max) begin
						err_q   <= 1'b1;
						steps_q <= '0;
					end else begin
						steps_q <= steps_q - SW'(1);
						if (cur_day_q == len_cur) begin
							cur_day_q <= cds_pkg::DayFirst;
							if (cur_month_q == cds_pkg::MonthDec) begin
								cur_month_q <= cds_pkg::MonthJan;
								cur_year_q  <= cur_year_q + YW'(1);
							end else begin
								cur_month_q <= cur_month_q + MW'(1);
							end
						end else begin
							cur_day_q <= cur_day_q + DW'(1);
						end
					end
				end else begin
					if (at_min) begin
						err_q   <= 1'b1;
						steps_q <= '0;
					end else begin
						steps_q <= steps_q - SW'(1);
						if (cur_day_q == cds_pkg::DayFirst) begin
							if (cur_month_q == cds_pkg::MonthJan) begin
								cur_month_q <= cds_pkg::MonthDec;
								cur_day_q   <= cds_pkg::DayLast;
								cur_year_q  <= cur_year_q - YW'(1);
							end else begin
								cur_month_q <= month_prev;
								cur_day_q   <= len_prev;
							end
						end else begin
							cur_day_q <= cur_day_q - DW'(1);
						end
					end
				end
			end
		end
	end

	// weekday pipeline, Jan/Feb as months 13/14 of the year before
	logic          early;
	logic [MW-1:0] wm_s1;
	logic [YW-1:0] wy_s1;
	logic [DW-1:0] wd_s1;
	logic [P100W-1:0] wy_prod;
	logic [7:0]       wq100_s2;
	logic [YW-1:0]    wp_s2;
	logic [YW-1:0]    ws_s3;
	logic [P7W-1:0]   s_prod;
	logic [YW-1:0]    q7;
	logic [YW-1:0]    r7;

	assign early   = cur_month_q <= cds_pkg::MonthFeb;
	assign wy_prod = P100W'(wy_s1) * P100W'(cds_pkg::Recip100);
	assign s_prod  = P7W'(ws_s3) * P7W'(cds_pkg::Recip7);
	assign q7      = YW'(s_prod >> cds_pkg::Recip7Sh);
	assign r7      = ws_s3 - YW'(q7 * YW'(7));

	always_ff @(posedge clk) begin
		if (ctl.wd_prep) begin
			wm_s1 <= early ? cur_month_q + MW'(12) : cur_month_q;
			wy_s1 <= cur_year_q + cds_pkg::YearOffset - YW'(early);
			wd_s1 <= cur_day_q;
		end
		if (ctl.wd_mul) begin
			wq100_s2 <= wy_prod[cds_pkg::Recip100Sh +: 8];
			wp_s2    <= YW'(wd_s1) + YW'({wm_s1, 1'b0}) + YW'(cds_pkg::kl_month_term(wm_s1)) +
				wy_s1 + (wy_s1 >> 2);
		end
		if (ctl.wd_sum) begin
			ws_s3 <= wp_s2 - YW'(wq100_s2) + YW'(wq100_s2 >> 2);
		end
		if (ctl.out_load) begin
			year        <= cur_year_q;
			month       <= cur_month_q;
			day         <= cur_day_q;
			weekday     <= r7[cds_pkg::DowW-1:0];
			range_error <= err_q;
		end
	end

	`CDS_ASSERT(a_year_bound, cur_year_q <= cds_pkg::MaxYear, "stored year above upper bound")
	`CDS_ASSERT_NXT(a_clamp_max, ctl.walk && steps_q != '0 && !back_q && at_max, err_q && steps_q == '0, "upper bound not clamped")

endmodule
